// ----- sv/pcb3d_pkg.sv -----
package pcb3d_pkg;

  // fixed point format of the datapath
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 16;
  localparam int UNIT_W    = FRAC_BITS + 1;
  localparam int ACC_W     = FRAC_BITS + 8;
  localparam int PROD_W    = ACC_W + UNIT_W + 1;
  localparam int VAL_W     = FRAC_BITS + 5;
  localparam int OUT_W     = FRAC_BITS + 3;
  localparam int GRAD_W    = 4;
  localparam int NCORNER   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [UNIT_W-1:0]       UNIT_T    = UNIT_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] UNIT_ACC  = ACC_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] FIFTEEN_U = ACC_W'(15) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] TEN_U     = ACC_W'(10) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] UNIT_VAL  = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] TWO_U     = VAL_W'(2) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] NEG_TWO_U = -TWO_U;

  // gradient selection codes: signed sums of two corner offsets a, b, c
  typedef enum logic [GRAD_W-1:0] {
    GR_A_B   = 4'd0,
    GR_NA_B  = 4'd1,
    GR_A_NB  = 4'd2,
    GR_NA_NB = 4'd3,
    GR_A_C   = 4'd4,
    GR_NA_C  = 4'd5,
    GR_A_NC  = 4'd6,
    GR_NA_NC = 4'd7,
    GR_B_C   = 4'd8,
    GR_NB_C  = 4'd9,
    GR_B_NC  = 4'd10,
    GR_NB_NC = 4'd11
  } grad_op_t;

  typedef logic signed [VAL_W-1:0] val_t;

  // a * t / 2^FRAC_BITS, rounded half up (floor of sum with half)
  function automatic logic signed [ACC_W-1:0] mulq(input logic signed [ACC_W-1:0] a,
                                                   input logic [UNIT_W-1:0] t);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] ts;
    ts = $signed({{(PROD_W-UNIT_W){1'b0}}, t});
    p  = PROD_W'(a) * ts;
    p  = p + $signed(PROD_W'(1) << (FRAC_BITS - 1));
    return ACC_W'(p >>> FRAC_BITS);
  endfunction

endpackage

// ----- sv/pcb3d_corner.sv -----
module pcb3d_corner (
  input  logic                                          clk,
  input  logic [pcb3d_pkg::IN_W-1:0]                    frac_x,
  input  logic [pcb3d_pkg::IN_W-1:0]                    frac_y,
  input  logic [pcb3d_pkg::IN_W-1:0]                    frac_z,
  input  logic [pcb3d_pkg::NCORNER-1:0][pcb3d_pkg::GRAD_W-1:0] grad,
  output pcb3d_pkg::val_t                               g [pcb3d_pkg::NCORNER],
  output logic                                          ok
);

  pcb3d_pkg::val_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  pcb3d_pkg::val_t g_next [pcb3d_pkg::NCORNER];
  logic [pcb3d_pkg::NCORNER-1:0] bad;

  // corner-relative offsets: fraction for the low corner, fraction minus one for the high
  always_comb begin
    lo_x = $signed({{(pcb3d_pkg::VAL_W-pcb3d_pkg::FRAC_BITS){1'b0}},
                    frac_x[pcb3d_pkg::FRAC_BITS-1:0]});
    lo_y = $signed({{(pcb3d_pkg::VAL_W-pcb3d_pkg::FRAC_BITS){1'b0}},
                    frac_y[pcb3d_pkg::FRAC_BITS-1:0]});
    lo_z = $signed({{(pcb3d_pkg::VAL_W-pcb3d_pkg::FRAC_BITS){1'b0}},
                    frac_z[pcb3d_pkg::FRAC_BITS-1:0]});
    hi_x = lo_x - pcb3d_pkg::UNIT_VAL;
    hi_y = lo_y - pcb3d_pkg::UNIT_VAL;
    hi_z = lo_z - pcb3d_pkg::UNIT_VAL;
  end

  for (genvar k = 0; k < pcb3d_pkg::NCORNER; k++) begin : g_corner
    pcb3d_pkg::val_t oa, ob, oc;
    pcb3d_pkg::grad_op_t op;

    assign oa = ((k % 2) == 1)       ? hi_x : lo_x;
    assign ob = (((k / 2) % 2) == 1) ? hi_y : lo_y;
    assign oc = (((k / 4) % 2) == 1) ? hi_z : lo_z;
    assign op = pcb3d_pkg::grad_op_t'(grad[k]);
    assign bad[k] = grad[k] > pcb3d_pkg::GR_NB_NC;

    always_comb begin
      unique case (op)
        pcb3d_pkg::GR_A_B:   g_next[k] = oa + ob;
        pcb3d_pkg::GR_NA_B:  g_next[k] = ob - oa;
        pcb3d_pkg::GR_A_NB:  g_next[k] = oa - ob;
        pcb3d_pkg::GR_NA_NB: g_next[k] = -oa - ob;
        pcb3d_pkg::GR_A_C:   g_next[k] = oa + oc;
        pcb3d_pkg::GR_NA_C:  g_next[k] = oc - oa;
        pcb3d_pkg::GR_A_NC:  g_next[k] = oa - oc;
        pcb3d_pkg::GR_NA_NC: g_next[k] = -oa - oc;
        pcb3d_pkg::GR_B_C:   g_next[k] = ob + oc;
        pcb3d_pkg::GR_NB_C:  g_next[k] = oc - ob;
        pcb3d_pkg::GR_B_NC:  g_next[k] = ob - oc;
        pcb3d_pkg::GR_NB_NC: g_next[k] = -ob - oc;
        default:             g_next[k] = '0;
      endcase
    end

    always_ff @(posedge clk) begin
      g[k] <= g_next[k];
    end
  end

  always_ff @(posedge clk) begin
    ok <= ~|bad;
  end

endmodule

// ----- sv/pcb3d_fade.sv -----
module pcb3d_fade (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pcb3d_pkg::IN_W-1:0]     x,
  output logic [pcb3d_pkg::UNIT_W-1:0]   t
);

  logic [pcb3d_pkg::UNIT_W-1:0]       x0, x1, x2, x3;
  logic signed [pcb3d_pkg::ACC_W-1:0] s0, s1, s2, s3;
  logic signed [pcb3d_pkg::ACC_W-1:0] xs, s0_next, t_raw;
  logic [pcb3d_pkg::UNIT_W-1:0]       t_next;

  // stage 0: 6x - 15
  always_comb begin
    xs = $signed({{(pcb3d_pkg::ACC_W-pcb3d_pkg::FRAC_BITS){1'b0}},
                  x[pcb3d_pkg::FRAC_BITS-1:0]});
    s0_next = (xs <<< 2) + (xs <<< 1) - pcb3d_pkg::FIFTEEN_U;
  end

  // last stage: clamp to [0, 1]
  always_comb begin
    t_raw = pcb3d_pkg::mulq(s3, x3);
    if (t_raw < 0) begin
      t_next = '0;
    end else if (t_raw > pcb3d_pkg::UNIT_ACC) begin
      t_next = pcb3d_pkg::UNIT_T;
    end else begin
      t_next = t_raw[pcb3d_pkg::UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    x0 <= {1'b0, x[pcb3d_pkg::FRAC_BITS-1:0]};
    s0 <= s0_next;
    x1 <= x0;
    s1 <= pcb3d_pkg::mulq(s0, x0) + pcb3d_pkg::TEN_U;
    x2 <= x1;
    s2 <= pcb3d_pkg::mulq(s1, x1);
    x3 <= x2;
    s3 <= pcb3d_pkg::mulq(s2, x2);
    t  <= t_next;
  end

  fade_t_range: assert property (@(posedge clk) disable iff (rst) t <= pcb3d_pkg::UNIT_T)
    else $error("fade weight above one");

endmodule

// ----- sv/pcb3d_lerp.sv -----
module pcb3d_lerp (
  input  logic                         clk,
  input  pcb3d_pkg::val_t              a,
  input  pcb3d_pkg::val_t              b,
  input  logic [pcb3d_pkg::UNIT_W-1:0] t,
  output pcb3d_pkg::val_t              q
);

  pcb3d_pkg::val_t                    diff;
  logic signed [pcb3d_pkg::ACC_W-1:0] step;

  always_comb begin
    diff = b - a;
    step = pcb3d_pkg::mulq(pcb3d_pkg::ACC_W'(diff), t);
  end

  always_ff @(posedge clk) begin
    q <= a + pcb3d_pkg::VAL_W'(step);
  end

endmodule

// ----- sv/perlin_corner_blend_3d_top.sv -----
// 3d improved perlin noise, one cell: gradient dots, quintic fade, trilinear blend
// an item taken on start shows its result on done once it has passed the valid pipe and the done
// register; throughput one item per cycle while out of reset
// the pipeline never stalls: the receiver cannot hold results off
// rst is synchronous: clears the valid pipe and the gradient registers to 0
// busy follows rst, so start is refused only while reset is held
module perlin_corner_blend_3d_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pcb3d_pkg::IN_W-1:0]            frac_x,
  input  logic [pcb3d_pkg::IN_W-1:0]            frac_y,
  input  logic [pcb3d_pkg::IN_W-1:0]            frac_z,
  input  logic                                  cfg_we,
  input  logic [pcb3d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcb3d_pkg::GRAD_W-1:0]          cfg_data,
  output logic                                  done,
  output logic signed [pcb3d_pkg::OUT_W-1:0]    noise_value,
  output logic                                  valid_res
);

  localparam int DEPTH = 9;  // registers from input to result
  localparam int GDLY  = 4;  // corner values wait for the x fade

  logic [pcb3d_pkg::NCORNER-1:0][pcb3d_pkg::GRAD_W-1:0] grad;
  logic [DEPTH-2:0]             vpipe;
  logic [DEPTH-3:0]             okpipe;
  logic                         accept;
  logic                         ok0;
  pcb3d_pkg::val_t              g0 [pcb3d_pkg::NCORNER];
  pcb3d_pkg::val_t              gpipe [GDLY][pcb3d_pkg::NCORNER];
  logic [pcb3d_pkg::UNIT_W-1:0] tx, ty, tz;
  logic [pcb3d_pkg::UNIT_W-1:0] ty_d1, tz_d1, tz_d2;
  pcb3d_pkg::val_t              lx [4];
  pcb3d_pkg::val_t              ly [2];
  pcb3d_pkg::val_t              lz;
  pcb3d_pkg::val_t              sat;

  assign busy   = rst;
  assign accept = start & ~busy;

  // gradient register file; write it only while idle (the block itself does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      grad <= '0;
    end else if (cfg_we) begin
      grad[cfg_index] <= cfg_data;
    end
  end

  // valid bits ride alongside the data; the ok flag rides with them
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done  <= 1'b0;
    end else begin
      vpipe <= {vpipe[DEPTH-3:0], accept};
      done  <= vpipe[DEPTH-2];
    end
  end

  // ok0 is already one register in, so this pipe is one shorter
  always_ff @(posedge clk) begin
    okpipe <= {okpipe[DEPTH-4:0], ok0};
  end

  // stage 0: corner dot products
  pcb3d_corner u_corner (
    .clk    (clk),
    .frac_x (frac_x),
    .frac_y (frac_y),
    .frac_z (frac_z),
    .grad   (grad),
    .g      (g0),
    .ok     (ok0)
  );

  // stages 0..4: fade polynomial per axis, one rounded product in each of stages 1..4
  pcb3d_fade u_fade_x (.clk(clk), .rst(rst), .x(frac_x), .t(tx));
  pcb3d_fade u_fade_y (.clk(clk), .rst(rst), .x(frac_y), .t(ty));
  pcb3d_fade u_fade_z (.clk(clk), .rst(rst), .x(frac_z), .t(tz));

  // hold corner values until the fade weights arrive
  always_ff @(posedge clk) begin
    gpipe[0] <= g0;
    for (int i = 1; i < GDLY; i++) begin
      gpipe[i] <= gpipe[i-1];
    end
    ty_d1 <= ty;
    tz_d1 <= tz;
    tz_d2 <= tz_d1;
  end

  // stage 5: blend along x
  for (genvar j = 0; j < 4; j++) begin : g_lerp_x
    pcb3d_lerp u_lerp_x (
      .clk (clk),
      .a   (gpipe[GDLY-1][2*j]),
      .b   (gpipe[GDLY-1][2*j+1]),
      .t   (tx),
      .q   (lx[j])
    );
  end

  // stage 6: blend along y
  for (genvar j = 0; j < 2; j++) begin : g_lerp_y
    pcb3d_lerp u_lerp_y (
      .clk (clk),
      .a   (lx[2*j]),
      .b   (lx[2*j+1]),
      .t   (ty_d1),
      .q   (ly[j])
    );
  end

  // stage 7: blend along z
  pcb3d_lerp u_lerp_z (
    .clk (clk),
    .a   (ly[0]),
    .b   (ly[1]),
    .t   (tz_d2),
    .q   (lz)
  );

  // stage 8: saturate to [-2, 2], zero the value on a bad gradient index
  always_comb begin
    if (lz > pcb3d_pkg::TWO_U) begin
      sat = pcb3d_pkg::TWO_U;
    end else if (lz < pcb3d_pkg::NEG_TWO_U) begin
      sat = pcb3d_pkg::NEG_TWO_U;
    end else begin
      sat = lz;
    end
  end

  always_ff @(posedge clk) begin
    valid_res   <= okpipe[DEPTH-3];
    noise_value <= okpipe[DEPTH-3] ? pcb3d_pkg::OUT_W'(sat) : '0;
  end

  res_follows_item: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##9 done)
    else $error("item taken without a result");

  no_spurious_result: assert property (@(posedge clk)
    done |-> $past(accept, 9))
    else $error("result without an item");

  bad_grad_zero: assert property (@(posedge clk) disable iff (rst)
    done && !valid_res |-> noise_value == '0)
    else $error("nonzero value with bad gradient");

  value_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (noise_value <= pcb3d_pkg::OUT_W'(pcb3d_pkg::TWO_U)) &&
             (noise_value >= pcb3d_pkg::OUT_W'(pcb3d_pkg::NEG_TWO_U)))
    else $error("noise value out of range");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pcb3d_pkg::*;

  // one Q2.16 noise result as the block should report it
  typedef struct {
    logic signed [OUT_W-1:0] noise;
    logic                    valid;
  } noise_result_t;

  // all eight gradient codes, corner 0 in the low nibble
  typedef logic [NCORNER-1:0][GRAD_W-1:0] grad_cfg_t;

  localparam longint ONE_Q          = 64'sd1 << FRAC_BITS;
  localparam int     WATCHDOG_LIMIT = 400;
  localparam int     DRAIN_CYCLES   = 16;
  localparam int     RANDOM_PHASES  = 14;
  localparam int     ITEMS_PER_PHASE = 102;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IN_W-1:0]       frac_x = '0;
  logic [IN_W-1:0]       frac_y = '0;
  logic [IN_W-1:0]       frac_z = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [GRAD_W-1:0]     cfg_data = '0;
  logic                  done;
  logic signed [OUT_W-1:0] noise_value;
  logic                  valid_res;

  // our own copy of the gradient registers, mirrors what has been written
  logic [GRAD_W-1:0] grad_set [NCORNER];

  // predicted results, oldest first
  noise_result_t noise_results [$];
  noise_result_t oldest_result;

  int fail_count = 0;
  int idle_cycles = 0;
  int max_gap = 5;   // largest random sender gap drawn before each item

  perlin_corner_blend_3d_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .frac_x      (frac_x),
    .frac_y      (frac_y),
    .frac_z      (frac_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .noise_value (noise_value),
    .valid_res   (valid_res)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // noise predictor
  // ---------------------------------------------------------------------------

  // product scaled back by 2^FRAC_BITS, rounded half up (floor after adding half)
  function automatic longint scale_round(input longint a, input longint t);
    longint p;
    p = a * t + (64'sd1 <<< (FRAC_BITS - 1));
    return p >>> FRAC_BITS;
  endfunction

  // quintic fade 6t^5 - 15t^4 + 10t^3, one rounding per multiply, clamped to [0, 1]
  function automatic longint fade_q(input longint x);
    longint s;
    s = 6 * x - 15 * ONE_Q;
    s = scale_round(s, x) + 10 * ONE_Q;
    s = scale_round(s, x);
    s = scale_round(s, x);
    s = scale_round(s, x);
    if (s < 0) s = 0;
    if (s > ONE_Q) s = ONE_Q;
    return s;
  endfunction

  function automatic longint lerp_q(input longint t, input longint a, input longint b);
    return a + scale_round(b - a, t);
  endfunction

  // signed sum of two corner offsets, picked by the gradient code
  function automatic longint gradient_dot(input logic [GRAD_W-1:0] code,
                                          input longint a, input longint b,
                                          input longint c);
    case (grad_op_t'(code))
      GR_A_B:   return a + b;
      GR_NA_B:  return -a + b;
      GR_A_NB:  return a - b;
      GR_NA_NB: return -a - b;
      GR_A_C:   return a + c;
      GR_NA_C:  return -a + c;
      GR_A_NC:  return a - c;
      GR_NA_NC: return -a - c;
      GR_B_C:   return b + c;
      GR_NB_C:  return -b + c;
      GR_B_NC:  return b - c;
      GR_NB_NC: return -b - c;
      default:  return 0;
    endcase
  endfunction

  function automatic noise_result_t predict_noise(input logic [IN_W-1:0] fx,
                                                  input logic [IN_W-1:0] fy,
                                                  input logic [IN_W-1:0] fz);
    noise_result_t res;
    longint g [NCORNER];
    longint x, y, z, tx, ty, tz, l0, l1, l2, l3, r;
    bit ok;
    x = fx;
    y = fy;
    z = fz;
    ok = 1'b1;
    // bit 0 of the corner number picks the high x side, bit 1 y, bit 2 z
    for (int k = 0; k < NCORNER; k++) begin
      if (grad_set[k] > GR_NB_NC) ok = 1'b0;
      g[k] = gradient_dot(grad_set[k],
                          (k & 1) ? x - ONE_Q : x,
                          (k & 2) ? y - ONE_Q : y,
                          (k & 4) ? z - ONE_Q : z);
    end
    if (!ok) begin
      res.noise = '0;
      res.valid = 1'b0;
      return res;
    end
    tx = fade_q(x);
    ty = fade_q(y);
    tz = fade_q(z);
    l0 = lerp_q(tx, g[0], g[1]);
    l1 = lerp_q(tx, g[2], g[3]);
    l2 = lerp_q(tx, g[4], g[5]);
    l3 = lerp_q(tx, g[6], g[7]);
    l0 = lerp_q(ty, l0, l1);
    l2 = lerp_q(ty, l2, l3);
    r  = lerp_q(tz, l0, l2);
    if (r > 2 * ONE_Q) r = 2 * ONE_Q;
    if (r < -2 * ONE_Q) r = -2 * ONE_Q;
    res.noise = r[OUT_W-1:0];
    res.valid = 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every strobed result is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_results.size() == 0) begin
        $error("unexpected result: noise_value %0d valid_res %0b", noise_value, valid_res);
        fail_count++;
      end else begin
        oldest_result = noise_results.pop_front();
        if (noise_value !== oldest_result.noise) begin
          $error("noise_value mismatch: expected %0d, actual %0d",
                 oldest_result.noise, noise_value);
          fail_count++;
        end
        if (valid_res !== oldest_result.valid) begin
          $error("valid_res mismatch: expected %0b, actual %0b",
                 oldest_result.valid, valid_res);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long with no item taken and no result out means a hang
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item; start is left high so a back-to-back item keeps it up
  task automatic send_point(input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
                            input logic [IN_W-1:0] pz);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    frac_x <= px;
    frac_y <= py;
    frac_z <= pz;
    do @(posedge clk); while (busy);
    // taken at this edge: registers cannot change under us, predict now
    noise_results.push_back(predict_noise(px, py, pz));
  endtask

  // stop offering items and wait until every predicted result has been seen
  task automatic settle();
    start <= 1'b0;
    while (noise_results.size() != 0) @(posedge clk);
  endtask

  // write all eight gradient registers, only while the pipe is empty
  task automatic apply_config(input grad_cfg_t codes);
    settle();
    for (int k = 0; k < NCORNER; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= codes[k];
      @(posedge clk);
      grad_set[k] = codes[k];
    end
    cfg_we <= 1'b0;
  endtask

  // cell fraction with extra weight on the edges of the range
  function automatic logic [IN_W-1:0] pick_frac();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return IN_W'($urandom_range(0, 255));
      3:       return '1 - IN_W'($urandom_range(0, 255));
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic grad_cfg_t uniform_config(input logic [GRAD_W-1:0] code);
    grad_cfg_t c;
    for (int k = 0; k < NCORNER; k++) c[k] = code;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers come out of reset as code 0 on every corner
  task automatic test_reset_defaults();
    send_point('0, '0, '0);
    send_point('1, '1, '1);
    send_point(16'h8000, 16'h0001, 16'hFFFE);
  endtask

  // every valid gradient code on all corners, the point picked from the loop index (z random when bit 2 is clear)
  task automatic test_each_gradient_op();
    grad_op_t op;
    op = op.first();
    for (int n = 0; n < 12; n++) begin
      apply_config(uniform_config(op));
      send_point((n & 1) ? '1 : '0, (n & 2) ? '1 : 16'h8000,
                 (n & 4) ? 16'h0001 : IN_W'($urandom));
      op = op.next();
    end
  endtask

  // any code above the last valid one clears the valid flag and the value
  task automatic test_bad_gradient_index();
    grad_cfg_t c;
    c = uniform_config(GR_B_C);
    c[5] = 4'd12;
    apply_config(c);
    send_point(16'h4000, 16'hC000, 16'h2000);
    c = uniform_config(GR_NA_C);
    c[0] = 4'd15;
    apply_config(c);
    send_point('1, '0, '1);
  endtask

  // a different code on each corner, so the blend order matters
  task automatic test_mixed_corners();
    apply_config({GR_NB_NC, GR_NA_NC, GR_B_NC, GR_NA_B, GR_A_C, GR_NB_C, GR_A_NB, GR_A_B});
    send_point(16'h1234, 16'hABCD, 16'h7FFF);
    send_point('1, '1, '0);
    send_point(16'h8000, 16'h8000, 16'h8000);
  endtask

  // random points over several register settings, with and without sender gaps
  task automatic test_random_cells();
    grad_cfg_t c;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: c = uniform_config(GR_A_B);
        1: c = uniform_config(GR_NB_NC);
        2: c = uniform_config(4'hF);
        default: begin
          // mostly valid codes, now and then some out-of-range ones
          for (int k = 0; k < NCORNER; k++)
            c[k] = ($urandom_range(0, 5) == 0) ? GRAD_W'($urandom_range(0, 15))
                                                : GRAD_W'($urandom_range(0, GR_NB_NC));
        end
      endcase
      apply_config(c);
      // every third phase runs back-to-back, the others mix gaps with back-to-back runs
      max_gap = (phase % 3 == 1) ? 0 : 5;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (max_gap != 0 && $urandom_range(0, 15) == 0) max_gap = 0;
        else if (max_gap == 0 && phase % 3 != 1 && $urandom_range(0, 7) == 0) max_gap = 5;
        send_point(pick_frac(), pick_frac(), pick_frac());
      end
      max_gap = 5;
    end
  endtask

  initial begin
    for (int k = 0; k < NCORNER; k++) grad_set[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_each_gradient_op();
    test_bad_gradient_index();
    test_mixed_corners();
    test_random_cells();

    // drain, then give stray results a chance to show up
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
